>>> rtl/ftss_pkg.sv
// Shared constants, types and rounding helpers for the flat-base triangle span generator.
// No dependencies; every other file imports this package.
`default_nettype none
package ftss_pkg;

    localparam int MAX_ROWS        = 64;
    localparam int COORD_FRAC_BITS = 8;

    localparam int CW    = 24;                      // vertex coordinate width
    localparam int XW    = 12;                      // pixel column width
    localparam int YW    = 6;                       // clip_max_y width
    localparam int ROW_W = 6;                       // pixel row width
    localparam int CLR_W = 8;

    localparam logic [ROW_W-1:0] ROW_LIM = ROW_W'(MAX_ROWS - 1);

    // coordinates scaled to 2^-16 units
    localparam int SCL_SH = 16 - COORD_FRAC_BITS;
    localparam int TS_W   = CW + SCL_SH;
    localparam int V_W    = TS_W + 1;
    localparam int CT_W   = V_W - 16;               // width of a rounded coordinate

    localparam int D_W   = 25;                      // |dy|
    localparam int DX_W  = 25;                      // dx, signed
    localparam int MA_W  = TS_W + 1;
    localparam int MB_W  = 26;
    localparam int MP_W  = MA_W + MB_W;
    localparam int NUM_W = TS_W + 28;               // intercept numerator magnitude
    localparam int QW    = NUM_W + 1;               // signed quotient
    localparam int DEN_W = D_W + 16;
    localparam int CNT_W = $clog2(NUM_W + 1);

    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 12;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_Y = 1'b1;

    typedef struct packed {
        logic load;
        logic sort;
        logic range;
        logic mul0;
        logic mul1;
        logic mul2;
        logic sum;
        logic div_start;
        logic fix;
        logic emit_row;
        logic emit_none;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic div_busy;
        logic out_free;
        logic row_last;
    } t_stat;

    typedef struct packed {
        logic signed [QW-1:0] q;
        logic [DEN_W-1:0]     r;
    } t_qr;

    // ceil(v - 2^-16)
    function automatic logic signed [CT_W-1:0] ceil_tol(input logic signed [CW-1:0] v);
        logic signed [V_W-1:0] s;
        s = (V_W'(v) <<< SCL_SH) + V_W'(65534);
        return s[V_W-1:16];
    endfunction

    // floor(v + 2^-16)
    function automatic logic signed [CT_W-1:0] floor_tol(input logic signed [CW-1:0] v);
        logic signed [V_W-1:0] s;
        s = (V_W'(v) <<< SCL_SH) + V_W'(1);
        return s[V_W-1:16];
    endfunction

endpackage
`default_nettype wire

>>> rtl/ftss_in_if.sv
// Triangle input channel: valid/ready plus vertex and colour payload.
// Depends on ftss_pkg.
`default_nettype none
interface ftss_in_if import ftss_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [CW-1:0]   ax;
    logic signed [CW-1:0]   ay;
    logic signed [CW-1:0]   bx;
    logic signed [CW-1:0]   by;
    logic signed [CW-1:0]   cx;
    logic signed [CW-1:0]   cy;
    logic [CLR_W-1:0]       red_in;
    logic [CLR_W-1:0]       green_in;
    logic [CLR_W-1:0]       blue_in;

    modport source (output valid, ax, ay, bx, by, cx, cy, red_in, green_in, blue_in,
                    input ready);
    modport sink   (input valid, ax, ay, bx, by, cx, cy, red_in, green_in, blue_in,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/ftss_out_if.sv
// Span result channel: valid/ready plus row, column range, colour and flags.
// Depends on ftss_pkg.
`default_nettype none
interface ftss_out_if import ftss_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ROW_W-1:0]   row;
    logic [XW-1:0]      x_start;
    logic [XW-1:0]      x_end;
    logic [CLR_W-1:0]   red_out;
    logic [CLR_W-1:0]   green_out;
    logic [CLR_W-1:0]   blue_out;
    logic               span_valid;
    logic               last;

    modport source (output valid, row, x_start, x_end, red_out, green_out, blue_out,
                    span_valid, last, input ready);
    modport sink   (input valid, row, x_start, x_end, red_out, green_out, blue_out,
                    span_valid, last, output ready);
endinterface
`default_nettype wire

>>> rtl/ftss_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ftss_pkg.
`default_nettype none
module ftss_div import ftss_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [NUM_W-1:0]   i_dividend,
    input  wire logic [DEN_W-1:0]   i_divisor,
    output logic                    o_busy,
    output logic [NUM_W-1:0]        o_quot,
    output logic [DEN_W-1:0]        o_rem
);
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_dv;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             ge;

    always_comb begin
        rem_sh  = {r_rem, r_q[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_dv};
        ge      = rem_sh >= {1'b0, r_dv};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dv  <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], ge};
            r_rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

>>> rtl/ftss_datapath.sv
// Datapath: vertex sort, row range, intercept set-up, edge stepping and output register.
// Depends on ftss_pkg and ftss_div.
`default_nettype none
module ftss_datapath import ftss_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cmd                   i_cmd,
    output t_stat                       o_stat,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_W-1:0]       i_cfg_data,
    input  wire logic signed [CW-1:0]   i_ax,
    input  wire logic signed [CW-1:0]   i_ay,
    input  wire logic signed [CW-1:0]   i_bx,
    input  wire logic signed [CW-1:0]   i_by,
    input  wire logic signed [CW-1:0]   i_cx,
    input  wire logic signed [CW-1:0]   i_cy,
    input  wire logic [CLR_W-1:0]       i_red,
    input  wire logic [CLR_W-1:0]       i_green,
    input  wire logic [CLR_W-1:0]       i_blue,
    input  wire logic                   i_out_ready,
    output logic                        o_out_valid,
    output logic [ROW_W-1:0]            o_row,
    output logic [XW-1:0]               o_x_start,
    output logic [XW-1:0]               o_x_end,
    output logic [CLR_W-1:0]            o_red,
    output logic [CLR_W-1:0]            o_green,
    output logic [CLR_W-1:0]            o_blue,
    output logic                        o_span_valid,
    output logic                        o_last
);
    // configuration
    logic [XW-1:0] r_cmx;
    logic [YW-1:0] r_cmy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmx <= XW'(999);
            r_cmy <= YW'(63);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CLIP_X: r_cmx <= i_cfg_data[XW-1:0];
                REG_CLIP_Y: r_cmy <= i_cfg_data[YW-1:0];
                default: ;
            endcase
        end
    end

    // captured item
    logic signed [CW-1:0] r_x0, r_y0, r_x1, r_y1, r_x2, r_y2;
    logic [CLR_W-1:0]     r_red, r_green, r_blue;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x0 <= i_ax;  r_y0 <= i_ay;
            r_x1 <= i_bx;  r_y1 <= i_by;
            r_x2 <= i_cx;  r_y2 <= i_cy;
            r_red <= i_red; r_green <= i_green; r_blue <= i_blue;
        end
    end

    // base / tip selection
    logic signed [CW-1:0] s_tx, s_ty, s_by, s_pax, s_pbx;
    logic signed [CW-1:0] r_tx, r_ty, r_by, r_b1x, r_b2x;

    always_comb begin
        if (r_y0 == r_y1) begin
            s_pax = r_x0; s_pbx = r_x1; s_by = r_y0; s_tx = r_x2; s_ty = r_y2;
        end else if (r_y0 == r_y2) begin
            s_pax = r_x0; s_pbx = r_x2; s_by = r_y0; s_tx = r_x1; s_ty = r_y1;
        end else begin
            s_pax = r_x1; s_pbx = r_x2; s_by = r_y1; s_tx = r_x0; s_ty = r_y0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sort) begin
            r_tx  <= s_tx;
            r_ty  <= s_ty;
            r_by  <= s_by;
            r_b1x <= (s_pax < s_pbx) ? s_pax : s_pbx;
            r_b2x <= (s_pax < s_pbx) ? s_pbx : s_pax;
        end
    end

    // row range and edge set-up
    logic signed [CT_W-1:0] lo_f, hi_f, lo_c, hi_c, lim_s;
    logic [ROW_W-1:0]       lim;
    logic signed [DX_W-1:0] dy, dxl, dxr;
    logic                   dy_zero;

    logic                   r_empty, r_dyneg, r_degl, r_degr;
    logic [ROW_W-1:0]       r_row, r_hi;
    logic [D_W-1:0]         r_dabs;
    logic signed [DX_W-1:0] r_dxl, r_dxr;
    logic signed [CT_W-1:0] r_cl, r_cr;

    always_comb begin
        lo_f  = ceil_tol(r_ty);
        hi_f  = floor_tol(r_by);
        lim   = (r_cmy > ROW_LIM) ? ROW_LIM : r_cmy;
        lim_s = $signed(CT_W'(lim));
        lo_c  = (lo_f < 0) ? '0 : lo_f;
        hi_c  = (hi_f > lim_s) ? lim_s : hi_f;
        dy    = DX_W'(r_by) - DX_W'(r_ty);
        dxl   = DX_W'(r_b1x) - DX_W'(r_tx);
        dxr   = DX_W'(r_b2x) - DX_W'(r_tx);
        dy_zero = (dy == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.range) begin
            r_empty <= lo_c > hi_c;
            r_row   <= lo_c[ROW_W-1:0];
            r_hi    <= hi_c[ROW_W-1:0];
            r_dyneg <= dy[DX_W-1];
            r_dabs  <= dy[DX_W-1] ? D_W'(-dy) : D_W'(dy);
            r_dxl   <= dxl;
            r_dxr   <= dxr;
            r_degl  <= dy_zero || (dxl == '0);
            r_degr  <= dy_zero || (dxr == '0);
            r_cl    <= ceil_tol(r_b1x);
            r_cr    <= floor_tol(r_b2x);
        end else if (i_cmd.emit_row) begin
            r_row <= r_row + 1'b1;
        end
    end

    // shared multiplier: tip X times |dy|, then row offset times each dx
    logic signed [MA_W-1:0] txs, coef, mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] prod;
    logic signed [MP_W-1:0] r_p0, r_p1, r_p2;

    always_comb begin
        txs   = MA_W'(r_tx) <<< SCL_SH;
        coef  = $signed(MA_W'({r_row, 16'b0})) - (MA_W'(r_ty) <<< SCL_SH);
        mul_a = i_cmd.mul0 ? txs : coef;
        if (i_cmd.mul0) begin
            mul_b = $signed(MB_W'(r_dabs));
        end else if (i_cmd.mul1) begin
            mul_b = MB_W'(r_dxl);
        end else begin
            mul_b = MB_W'(r_dxr);
        end
        prod = mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul0) r_p0 <= prod;
        if (i_cmd.mul1) r_p1 <= prod;
        if (i_cmd.mul2) r_p2 <= prod;
    end

    // numerators and per-row steps, split into sign and magnitude
    logic signed [NUM_W-1:0] p0e, p1e, p2e, de, nl, nr, nu, nd;
    logic [DX_W-1:0]         dxl_abs, dxr_abs;

    logic [NUM_W-1:0] r_mu, r_md, r_msl, r_msr;
    logic             r_nu_neg, r_nd_neg, r_sl_neg, r_sr_neg;
    logic [DEN_W-1:0] r_den;

    always_comb begin
        p0e = NUM_W'(r_p0);
        p1e = NUM_W'(r_p1);
        p2e = NUM_W'(r_p2);
        de  = $signed(NUM_W'(r_dabs));
        nl  = r_dyneg ? -p1e : p1e;
        nr  = r_dyneg ? -p2e : p2e;
        nu  = p0e - de + nl;
        nd  = p0e + de + nr;
        dxl_abs = r_dxl[DX_W-1] ? DX_W'(-r_dxl) : DX_W'(r_dxl);
        dxr_abs = r_dxr[DX_W-1] ? DX_W'(-r_dxr) : DX_W'(r_dxr);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_nu_neg <= nu[NUM_W-1];
            r_nd_neg <= nd[NUM_W-1];
            r_mu     <= nu[NUM_W-1] ? NUM_W'(-nu) : NUM_W'(nu);
            r_md     <= nd[NUM_W-1] ? NUM_W'(-nd) : NUM_W'(nd);
            r_sl_neg <= r_dxl[DX_W-1] ^ r_dyneg;
            r_sr_neg <= r_dxr[DX_W-1] ^ r_dyneg;
            r_msl    <= NUM_W'({dxl_abs, 16'b0});
            r_msr    <= NUM_W'({dxr_abs, 16'b0});
            r_den    <= {r_dabs, 16'b0};
        end
    end

    logic [NUM_W-1:0] qu, qd, qsl, qsr;
    logic [DEN_W-1:0] ru, rd, rsl, rsr;
    logic [3:0]       busy;

    ftss_div u_div_u (.i_clk, .i_rst_n, .i_start(i_cmd.div_start), .i_dividend(r_mu),
                      .i_divisor(r_den), .o_busy(busy[0]), .o_quot(qu), .o_rem(ru));
    ftss_div u_div_d (.i_clk, .i_rst_n, .i_start(i_cmd.div_start), .i_dividend(r_md),
                      .i_divisor(r_den), .o_busy(busy[1]), .o_quot(qd), .o_rem(rd));
    ftss_div u_div_sl (.i_clk, .i_rst_n, .i_start(i_cmd.div_start), .i_dividend(r_msl),
                       .i_divisor(r_den), .o_busy(busy[2]), .o_quot(qsl), .o_rem(rsl));
    ftss_div u_div_sr (.i_clk, .i_rst_n, .i_start(i_cmd.div_start), .i_dividend(r_msr),
                       .i_divisor(r_den), .o_busy(busy[3]), .o_quot(qsr), .o_rem(rsr));

    // floor division of a signed value: remainder kept in [0, den)
    function automatic t_qr floor_fix(input logic neg, input logic [NUM_W-1:0] q,
                                      input logic [DEN_W-1:0] r, input logic [DEN_W-1:0] d);
        t_qr                  res;
        logic signed [QW-1:0] qs;
        qs = $signed({1'b0, q});
        if (!neg) begin
            res.q = qs;
            res.r = r;
        end else if (r != '0) begin
            res.q = -qs - QW'(1);
            res.r = d - r;
        end else begin
            res.q = -qs;
            res.r = '0;
        end
        return res;
    endfunction

    t_qr                  r_eu, r_ed, r_esl, r_esr;
    logic [DEN_W:0]       sum_u, sum_d;
    logic signed [QW-1:0] xs_raw, xe_raw, xs, xe, cmx_s;
    logic                 span_ok, row_last;

    always_comb begin
        sum_u  = {1'b0, r_eu.r} + {1'b0, r_esl.r};
        sum_d  = {1'b0, r_ed.r} + {1'b0, r_esr.r};
        xs_raw = r_degl ? QW'(r_cl) : r_eu.q + QW'(r_eu.r != '0);
        xe_raw = r_degr ? QW'(r_cr) : r_ed.q;
        cmx_s  = $signed(QW'(r_cmx));
        xs     = (xs_raw < 0) ? '0 : xs_raw;
        xe     = (xe_raw > cmx_s) ? cmx_s : xe_raw;
        span_ok  = xs <= xe;
        row_last = r_row == r_hi;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fix) begin
            r_eu  <= floor_fix(r_nu_neg, qu, ru, r_den);
            r_ed  <= floor_fix(r_nd_neg, qd, rd, r_den);
            r_esl <= floor_fix(r_sl_neg, qsl, rsl, r_den);
            r_esr <= floor_fix(r_sr_neg, qsr, rsr, r_den);
        end else if (i_cmd.emit_row) begin
            // step both edges one row: quotient plus step, carry out of the remainder
            if (sum_u >= {1'b0, r_den}) begin
                r_eu.r <= DEN_W'(sum_u - {1'b0, r_den});
                r_eu.q <= r_eu.q + r_esl.q + QW'(1);
            end else begin
                r_eu.r <= sum_u[DEN_W-1:0];
                r_eu.q <= r_eu.q + r_esl.q;
            end
            if (sum_d >= {1'b0, r_den}) begin
                r_ed.r <= DEN_W'(sum_d - {1'b0, r_den});
                r_ed.q <= r_ed.q + r_esr.q + QW'(1);
            end else begin
                r_ed.r <= sum_d[DEN_W-1:0];
                r_ed.q <= r_ed.q + r_esr.q;
            end
        end
    end

    // output register
    logic r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit_row || i_cmd.emit_none) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_row) begin
            o_row        <= r_row;
            o_x_start    <= span_ok ? xs[XW-1:0] : '0;
            o_x_end      <= span_ok ? xe[XW-1:0] : '0;
            o_span_valid <= span_ok;
            o_last       <= row_last;
            o_red        <= r_red;
            o_green      <= r_green;
            o_blue       <= r_blue;
        end else if (i_cmd.emit_none) begin
            o_row        <= '0;
            o_x_start    <= '0;
            o_x_end      <= '0;
            o_span_valid <= 1'b0;
            o_last       <= 1'b1;
            o_red        <= r_red;
            o_green      <= r_green;
            o_blue       <= r_blue;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_stat.empty    = r_empty;
    assign o_stat.div_busy = |busy;
    assign o_stat.out_free = !r_ov || i_out_ready;
    assign o_stat.row_last = row_last;
endmodule
`default_nettype wire

>>> rtl/ftss_ctrl.sv
// Controller state machine: sequences set-up, division and one span per row, or a single empty item.
// Depends on ftss_pkg.
`default_nettype none
module ftss_ctrl import ftss_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_in_valid,
    output logic        o_in_ready,
    input  wire t_stat  i_stat,
    output t_cmd        o_cmd
);
    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_SORT   = 12'b0000_0000_0010,
        S_RANGE  = 12'b0000_0000_0100,
        S_MUL0   = 12'b0000_0000_1000,
        S_MUL1   = 12'b0000_0001_0000,
        S_MUL2   = 12'b0000_0010_0000,
        S_SUM    = 12'b0000_0100_0000,
        S_DSTART = 12'b0000_1000_0000,
        S_DWAIT  = 12'b0001_0000_0000,
        S_FIX    = 12'b0010_0000_0000,
        S_ROWS   = 12'b0100_0000_0000,
        S_NONE   = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SORT;
                end
            end
            S_SORT: begin
                o_cmd.sort = 1'b1;
                n_state    = S_RANGE;
            end
            S_RANGE: begin
                o_cmd.range = 1'b1;
                n_state     = S_MUL0;
            end
            S_MUL0: begin
                // empty flag is valid from here on
                if (i_stat.empty) begin
                    n_state = S_NONE;
                end else begin
                    o_cmd.mul0 = 1'b1;
                    n_state    = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_ROWS;
            end
            S_ROWS: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_row = 1'b1;
                    if (i_stat.row_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_NONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_none = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/flat_triangle_scanline_spans.sv
// Top level of the flat-base triangle span generator.
// Depends on ftss_pkg, ftss_in_if, ftss_out_if, ftss_ctrl and ftss_datapath.
//
// One triangle item (Q16.8 vertices, one pair sharing Y) yields one span item per
// covered row, last set on the final one; a triangle covering no rows yields a single
// empty item. Items are handled one at a time: set-up runs the bit-serial dividers,
// which produce exact edge intercepts and per-row steps, then emits one span per
// cycle while the output is taken. Exact rational stepping keeps every span
// bit-identical to the integer definition. The output register lets a new
// triangle be accepted while the last span still waits. clip_max_x and clip_max_y
// are written through the config port; the user must write them only while idle,
// which the block itself does not enforce.
`default_nettype none
module flat_triangle_scanline_spans import ftss_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    ftss_in_if.sink                     i_tri,
    ftss_out_if.source                  o_span,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_W-1:0]       i_cfg_data
);
    t_cmd  cmd;
    t_stat stat;

    ftss_ctrl u_ctrl (
        .i_clk,
        .i_rst_n,
        .i_in_valid (i_tri.valid),
        .o_in_ready (i_tri.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ftss_datapath u_dp (
        .i_clk,
        .i_rst_n,
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_we,
        .i_cfg_idx,
        .i_cfg_data,
        .i_ax         (i_tri.ax),
        .i_ay         (i_tri.ay),
        .i_bx         (i_tri.bx),
        .i_by         (i_tri.by),
        .i_cx         (i_tri.cx),
        .i_cy         (i_tri.cy),
        .i_red        (i_tri.red_in),
        .i_green      (i_tri.green_in),
        .i_blue       (i_tri.blue_in),
        .i_out_ready  (o_span.ready),
        .o_out_valid  (o_span.valid),
        .o_row        (o_span.row),
        .o_x_start    (o_span.x_start),
        .o_x_end      (o_span.x_end),
        .o_red        (o_span.red_out),
        .o_green      (o_span.green_out),
        .o_blue       (o_span.blue_out),
        .o_span_valid (o_span.span_valid),
        .o_last       (o_span.last)
    );
endmodule
`default_nettype wire
